// ===== hdl/tach_pkg.sv =====
// ----------------------------------------------------------------------------
// Tachometer package
// Shared widths, register indexes, input modes, controller states and control
// bundles.
// ----------------------------------------------------------------------------
package tach_pkg;

   localparam int SPEED_W          = 36;
   localparam int PERIOD_W         = 32;
   localparam int TIME_W           = 32;
   localparam int RATE_W           = 27;
   localparam int MARKS_W          = 8;
   localparam int LIMIT_W          = 32;
   localparam int DEN_W            = PERIOD_W + MARKS_W;
   localparam int SEC_PER_MIN      = 60;
   localparam int SEC_PER_MIN_W    = 6;
   localparam int FRAC_BITS_DEF    = 4;

   localparam int CSR_ADDR_W       = 2;
   localparam int CSR_DATA_W       = 32;

   localparam int REQ_DATA_W       = 64;
   localparam int RSP_DATA_W       = 40;

   localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(1000000);
   localparam logic [MARKS_W-1:0] MARKS_RST = MARKS_W'(2);
   localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1000);

   localparam logic [SPEED_W-1:0] SPEED_MAX = {SPEED_W{1'b1}};

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_TICK_RATE  = 2'd0,
      CSR_MARKS      = 2'd1,
      CSR_STALL_LIM  = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_CAPTURE = 1'b0,
      MODE_POLL    = 1'b1
   } req_mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic take_item;
      logic load_ops;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hdl/tach_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tachometer controller
// Sequences item intake, operand setup, serial divide and result commit.
// ----------------------------------------------------------------------------
module tach_ctrl
   import tach_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic          is_capture,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take_item = 1'b1;
               // only a capture with a nonzero period needs the divider
               state_in = is_capture ? ST_LOAD : ST_FINISH;
            end
         end
         ST_LOAD: begin
            cmd.load_ops = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register can take a new beat
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/tach_dp.sv =====
// ----------------------------------------------------------------------------
// Tachometer datapath
// Config registers, operand products, restoring divider, state and result.
// ----------------------------------------------------------------------------
module tach_dp
   import tach_pkg::*;
#(
   parameter int SPEED_FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_mode,
   input  logic [PERIOD_W-1:0]   req_period,
   input  logic [TIME_W-1:0]     req_time,
   output logic                  is_capture,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [SPEED_W-1:0]    rsp_speed,
   output logic                  rsp_stalled
);

   localparam int MUL_W = RATE_W + SEC_PER_MIN_W;
   localparam int NUM_W = MUL_W + SPEED_FRAC_BITS;
   localparam int QX_W  = (NUM_W > SPEED_W) ? NUM_W : SPEED_W;
   localparam int CNT_W = $clog2(NUM_W);

   logic [RATE_W-1:0]   rate_ff;
   logic [MARKS_W-1:0]  marks_ff;
   logic [LIMIT_W-1:0]  limit_ff;

   logic                mode_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [TIME_W-1:0]   time_ff;

   logic [NUM_W-1:0]    num_ff;
   logic [NUM_W-1:0]    num_in;
   logic [DEN_W-1:0]    den_ff;
   logic [DEN_W-1:0]    rem_ff;
   logic [DEN_W-1:0]    rem_in;
   logic [CNT_W-1:0]    cnt_ff;

   logic [SPEED_W-1:0]  speed_ff;
   logic [SPEED_W-1:0]  speed_in;
   logic [TIME_W-1:0]   edge_ff;
   logic                stall_ff;
   logic                stall_in;

   logic                out_valid_ff;
   logic [SPEED_W-1:0]  out_speed_ff;
   logic                out_stall_ff;

   logic [DEN_W:0]      trial;
   logic [DEN_W:0]      trial_diff;
   logic                trial_ge;
   logic [QX_W-1:0]     quot_ext;
   logic                quot_over;
   logic [TIME_W-1:0]   elapsed;
   logic                capt_ok;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RST;
         marks_ff <= MARKS_RST;
         limit_ff <= LIMIT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TICK_RATE: rate_ff  <= csr_wdata[RATE_W-1:0];
            CSR_MARKS:     marks_ff <= csr_wdata[MARKS_W-1:0];
            CSR_STALL_LIM: limit_ff <= csr_wdata[LIMIT_W-1:0];
            default:       ;
         endcase
      end
   end

   assign is_capture = (req_mode == MODE_CAPTURE) && (req_period != '0);

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         mode_ff   <= req_mode;
         period_ff <= req_period;
         time_ff   <= req_time;
      end
   end

   // one restoring divide step: shift a numerator bit into the remainder
   assign trial      = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge   = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};
   assign rem_in     = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
   assign num_in     = {num_ff[NUM_W-2:0], trial_ge};

   always_ff @(posedge clock) begin
      if (cmd.load_ops) begin
         num_ff <= NUM_W'(MUL_W'(rate_ff) * MUL_W'(SEC_PER_MIN)) << SPEED_FRAC_BITS;
         den_ff <= DEN_W'(period_ff) * DEN_W'(marks_ff);
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         num_ff <= num_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign status.div_last = (cnt_ff == CNT_W'(NUM_W - 1));
   assign status.out_free = !out_valid_ff || rsp_tready;

   // num_ff holds the quotient once the divide finishes
   assign quot_ext  = QX_W'(num_ff);
   assign quot_over = (quot_ext >> SPEED_W) != '0;
   assign elapsed   = time_ff - edge_ff;
   assign capt_ok   = (mode_ff == MODE_CAPTURE) && (period_ff != '0);

   always_comb begin
      speed_in = speed_ff;
      stall_in = stall_ff;
      if (capt_ok) begin
         if (den_ff == '0 || quot_over) begin
            speed_in = SPEED_MAX;
         end else begin
            speed_in = quot_ext[SPEED_W-1:0];
         end
         stall_in = 1'b0;
      end else if ((mode_ff == MODE_POLL) && !stall_ff && (elapsed > limit_ff)) begin
         speed_in = '0;
         stall_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         edge_ff  <= '0;
         stall_ff <= 1'b0;
      end else if (cmd.commit) begin
         speed_ff <= speed_in;
         stall_ff <= stall_in;
         if (capt_ok) begin
            edge_ff <= time_ff;
         end
      end
   end

   // result register: load on commit, drop once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_speed_ff <= speed_in;
         out_stall_ff <= stall_in;
      end
   end

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_speed   = out_speed_ff;
   assign rsp_stalled = out_stall_ff;

endmodule

// ===== hdl/tachometer_speed_with_stall_top.sv =====
// Sequence: a capture with nonzero period goes from accept through operand load and the
// one-bit-per-cycle restoring divider to commit. A poll or a zero-period capture goes
// from accept straight to commit. Throughput: one item at a time.
// A new beat is accepted while the previous result still waits on rsp.
// Reset: synchronous, active high; clears speed, edge time, stall flag and
// loads the default config (1 MHz tick, 2 marks, 1000 ms stall limit).
// ----------------------------------------------------------------------------
// Tachometer speed with stall detection
// Period capture to rpm (fixed point) and timeout-based stall flag.
// ----------------------------------------------------------------------------
module tachometer_speed_with_stall_top
   import tach_pkg::*;
#(
   parameter int SPEED_FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // period_count [31:0], time_ms [63:32]
   input  logic                  req_tuser,   // mode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // speed_rpm_q4 [35:0], zero pad [39:36]
   output logic                  rsp_tuser    // is_stalled
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic               is_capture;
   logic [SPEED_W-1:0] rsp_speed;

   tach_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .is_capture (is_capture),
      .status     (status),
      .cmd        (cmd)
   );

   tach_dp #(
      .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_mode    (req_tuser),
      .req_period  (req_tdata[PERIOD_W-1:0]),
      .req_time    (req_tdata[PERIOD_W +: TIME_W]),
      .is_capture  (is_capture),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_speed   (rsp_speed),
      .rsp_stalled (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(rsp_speed);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tachometer speed and stall testbench
// Drives capture and poll beats through several register settings. A
// scoreboard predicts speed and stall flag per beat and checks every result
// beat in order.
// ----------------------------------------------------------------------------

class tach_scoreboard;

   typedef struct packed {
      logic [tach_pkg::SPEED_W-1:0] speed;
      logic                         stalled;
   } speed_report_type;

   logic [tach_pkg::RATE_W-1:0]  tick_rate;
   logic [tach_pkg::MARKS_W-1:0] marks;
   logic [tach_pkg::LIMIT_W-1:0] limit;
   logic [tach_pkg::SPEED_W-1:0] speed;
   logic [tach_pkg::TIME_W-1:0]  last_edge;
   logic                         stalled;
   speed_report_type             expected_q[$];
   int errors;
   int checked;
   int captures;
   int polls;
   int stall_entries;

   function new();
      tick_rate     = tach_pkg::RATE_RST;
      marks         = tach_pkg::MARKS_RST;
      limit         = tach_pkg::LIMIT_RST;
      speed         = '0;
      last_edge     = '0;
      stalled       = 1'b0;
      errors        = 0;
      checked       = 0;
      captures      = 0;
      polls         = 0;
      stall_entries = 0;
   endfunction

   function void write_reg(logic [tach_pkg::CSR_ADDR_W-1:0] idx,
                           logic [tach_pkg::CSR_DATA_W-1:0] value);
      case (idx)
         tach_pkg::CSR_TICK_RATE: tick_rate = value[tach_pkg::RATE_W-1:0];
         tach_pkg::CSR_MARKS:     marks     = value[tach_pkg::MARKS_W-1:0];
         tach_pkg::CSR_STALL_LIM: limit     = value[tach_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // rpm * 16 = 60 * 16 * rate / (period * marks), saturated; zero divisor saturates
   function logic [tach_pkg::SPEED_W-1:0] rpm_q4(logic [tach_pkg::PERIOD_W-1:0] period);
      bit [63:0] num;
      bit [63:0] den;
      bit [63:0] quot;
      num = 64'(tach_pkg::SEC_PER_MIN) * (64'd1 << tach_pkg::FRAC_BITS_DEF)
            * 64'(tick_rate);
      den = 64'(period) * 64'(marks);
      if (den == 0)
         return tach_pkg::SPEED_MAX;
      quot = num / den;
      if (quot > 64'(tach_pkg::SPEED_MAX))
         return tach_pkg::SPEED_MAX;
      return quot[tach_pkg::SPEED_W-1:0];
   endfunction

   function void note_request(tach_pkg::req_mode_type mode,
                              logic [tach_pkg::PERIOD_W-1:0] period,
                              logic [tach_pkg::TIME_W-1:0] now);
      logic [tach_pkg::TIME_W-1:0] elapsed;
      speed_report_type            report;
      if (mode == tach_pkg::MODE_CAPTURE) begin
         captures++;
         if (period != '0) begin
            speed     = rpm_q4(period);
            last_edge = now;
            stalled   = 1'b0;
         end
      end else begin
         polls++;
         elapsed = now - last_edge;
         if (!stalled && elapsed > limit) begin
            speed   = '0;
            stalled = 1'b1;
            stall_entries++;
         end
      end
      report.speed   = speed;
      report.stalled = stalled;
      expected_q.push_back(report);
   endfunction

   function void check_result(logic [tach_pkg::SPEED_W-1:0] got_speed, logic got_stalled);
      speed_report_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected result beat: speed_rpm_q4=%0d is_stalled=%0b",
                got_speed, got_stalled);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got_speed !== want.speed) begin
         $error("speed_rpm_q4 mismatch: expected %0d, actual %0d", want.speed, got_speed);
         errors++;
      end
      if (got_stalled !== want.stalled) begin
         $error("is_stalled mismatch: expected %0b, actual %0b", want.stalled, got_stalled);
         errors++;
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

endclass

module tb_top;
   import tach_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int IDLE_PCT       = 34;
   localparam int RX_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES  = 60;
   localparam int WATCHDOG_LIMIT = 3000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // period_count [31:0], time_ms [63:32]
   logic                  req_tuser;   // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // speed_rpm_q4 [35:0], zero pad [39:36]
   logic                  rsp_tuser;   // is_stalled

   tach_scoreboard sb;

   logic              tx_idle_en;
   logic              rx_idle_en;
   int                hold_req_cnt;
   int                quiet_cycles;
   int                n_settings;
   logic [TIME_W-1:0] cur_time;
   logic [TIME_W-1:0] last_capture;
   logic [LIMIT_W-1:0] cfg_limit;

   tachometer_speed_with_stall_top #(
      .SPEED_FRAC_BITS (FRAC_BITS_DEF)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Beat monitors and the no-progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_mode_type'(req_tuser), req_tdata[PERIOD_W-1:0],
                            req_tdata[PERIOD_W +: TIME_W]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[SPEED_W-1:0], rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat accepted for %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Result side: random back-pressure, plus a long hold when requested
   initial begin : rx_driver
      int hold_done_cnt;
      hold_done_cnt = 0;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req_cnt != hold_done_cnt) begin
            hold_done_cnt = hold_req_cnt;
            rsp_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= !rx_idle_en || ($urandom_range(0, 99) >= IDLE_PCT);
            @(posedge clock);
         end
      end
   end

   task automatic send_item(req_mode_type mode, logic [PERIOD_W-1:0] period,
                            logic [TIME_W-1:0] now);
      while (tx_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {now, period};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering and hold until every expected result is back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic set_config(logic [CSR_DATA_W-1:0] rate, logic [CSR_DATA_W-1:0] marks,
                             logic [CSR_DATA_W-1:0] limit, bit poke_unmapped);
      if (poke_unmapped)
         write_csr(CSR_UNMAPPED, $urandom);
      write_csr(CSR_TICK_RATE, rate);
      write_csr(CSR_MARKS, marks);
      write_csr(CSR_STALL_LIM, limit);
      csr_we    <= 1'b0;
      cfg_limit  = limit;
      n_settings++;
   endtask

   // Mostly captures and polls that follow a running clock, with polls aimed
   // around the stall boundary; a few beats are pure noise.
   task automatic run_random(int count);
      req_mode_type        mode;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   now;
      logic [TIME_W-1:0]   delta;
      int                r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            mode = MODE_CAPTURE;
            r = $urandom_range(0, 99);
            if (r < 65)
               period = $urandom_range(1, 5000);
            else if (r < 80)
               period = $urandom;
            else if (r < 90)
               period = '0;
            else
               period = $urandom_range(1, 3);
            cur_time = cur_time + $urandom_range(0, 300);
            now = cur_time;
            if (period != '0)
               last_capture = now;
         end else if (r < 95) begin
            mode   = MODE_POLL;
            period = $urandom;
            r = $urandom_range(0, 99);
            if (r < 45)
               delta = cur_time - last_capture + $urandom_range(0, 50);
            else if (r < 80)
               delta = cfg_limit + $urandom_range(0, 2) - 1;
            else
               delta = $urandom;
            now = last_capture + delta;
            cur_time = now;
         end else begin
            mode   = req_mode_type'($urandom_range(0, 1));
            period = $urandom;
            now    = $urandom;
            if (mode == MODE_CAPTURE && period != '0)
               last_capture = now;
            cur_time = now;
         end
         send_item(mode, period, now);
      end
   endtask

   initial begin
      sb = new();
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_addr     = '0;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = MODE_CAPTURE;
      tx_idle_en   = 1'b1;
      rx_idle_en   = 1'b1;
      hold_req_cnt = 0;
      quiet_cycles = 0;
      n_settings   = 1;
      cur_time     = '0;
      last_capture = '0;
      cfg_limit    = LIMIT_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats at the reset settings (1 MHz, 2 marks, 1000 ms)
      send_item(MODE_POLL,    32'd0,          32'd0);
      send_item(MODE_CAPTURE, 32'd0,          32'd5);
      send_item(MODE_CAPTURE, 32'd1,          32'd10);
      send_item(MODE_CAPTURE, 32'hFFFF_FFFF,  32'd20);
      send_item(MODE_CAPTURE, 32'd2500,       32'd30);
      send_item(MODE_POLL,    32'hFFFF_FFFF,  32'd1030);   // exactly at the limit
      send_item(MODE_POLL,    32'd0,          32'd1031);   // one past: stall
      send_item(MODE_POLL,    32'd0,          32'd5000);   // already stalled
      send_item(MODE_CAPTURE, 32'd0,          32'd5001);   // zero period keeps stall
      send_item(MODE_CAPTURE, 32'd1234,       32'hFFFF_FF00);
      send_item(MODE_POLL,    32'd0,          32'h0000_02E7); // wrapped, 999 ms
      send_item(MODE_POLL,    32'd0,          32'h0000_02E9); // wrapped, 1001 ms
      send_item(MODE_CAPTURE, 32'd7,          32'hFFFF_FFFF);
      send_item(MODE_POLL,    32'd0,          32'hFFFF_FFFF);
      send_item(MODE_POLL,    32'd0,          32'hFFFF_FFFE); // elapsed wraps to max
      send_item(MODE_CAPTURE, 32'h8000_0000,  32'h8000_0000);
      send_item(MODE_CAPTURE, 32'hAAAA_AAAA,  32'h5555_5555);
      send_item(MODE_CAPTURE, 32'h5555_5555,  32'hAAAA_AAAA);
      cur_time     = 32'hAAAA_AAAA;
      last_capture = 32'hAAAA_AAAA;
      run_random(80);

      // Largest tick rate, one mark, zero limit: speed saturates
      wait_drained();
      set_config(32'd134217727, 32'd1, 32'd0, 1'b0);
      send_item(MODE_CAPTURE, 32'd1, cur_time);
      last_capture = cur_time;
      send_item(MODE_POLL, 32'd0, cur_time);
      cur_time = cur_time + 1;
      send_item(MODE_POLL, 32'hFFFF_FFFF, cur_time);
      run_random(40);
      hold_req_cnt <= hold_req_cnt + 1;   // long receiver hold, sender keeps offering
      run_random(50);

      // Zero marks: divisor is zero; stall limit at its top never expires
      wait_drained();
      set_config(32'd12345, 32'd0, 32'hFFFF_FFFF, 1'b0);
      run_random(70);

      // Zero tick rate
      wait_drained();
      set_config(32'd0, 32'd255, 32'd50, 1'b0);
      run_random(70);

      wait_drained();
      set_config(32'd1, 32'd1, 32'd1, 1'b0);
      run_random(60);

      // Long stretch with no idling on either side
      wait_drained();
      tx_idle_en <= 1'b0;
      rx_idle_en <= 1'b0;
      set_config(32'd100000000, 32'd255, 32'd20000, 1'b0);
      run_random(110);

      // Upper write-data bits beyond each register are dropped
      wait_drained();
      tx_idle_en <= 1'b1;
      rx_idle_en <= 1'b1;
      set_config(32'hF80F_4240, 32'hFFFF_FF03, 32'd700, 1'b1);
      run_random(40);
      wait_drained();
      run_random(40);

      wait_drained();
      $display("Run covered %0d capture and %0d poll beats over %0d register settings.",
               sb.captures, sb.polls, n_settings);
      $display("%0d results checked, %0d stall entries, %0d mismatches.",
               sb.checked, sb.stall_entries, sb.errors);
      if (sb.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tach_pkg.sv
hdl/tach_ctrl.sv
hdl/tach_dp.sv
hdl/tachometer_speed_with_stall_top.sv
verif/tb_top.sv
